### rtl/wav_stream_sample_decoder_core_defines.svh
// assertion macros for the wav stream sample decoder
`ifndef WAV_STREAM_SAMPLE_DECODER_CORE_DEFINES_SVH
`define WAV_STREAM_SAMPLE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/wav_sd_pkg.sv
package wav_sd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NOT_WAVE  = 3'd1,
    ERR_ENCODING  = 3'd2,
    ERR_LAYOUT    = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_MISSING   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    MODE_PCM16 = 2'd0,
    MODE_PCM24 = 2'd1,
    MODE_PCM32 = 2'd2,
    MODE_FLOAT = 2'd3
  } mode_e;

  // one queue entry: an optional sample followed by an optional finish/error
  typedef struct packed {
    logic        smp_vld;
    logic [31:0] raw;
    mode_e       mode;
    logic [15:0] chan;
    logic        term_vld;
    kind_e       term_kind;
    err_e        err;
    logic [31:0] rate;
    logic [15:0] count;
  } rec_t;

endpackage

### rtl/wav_sd_front.sv
module wav_sd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_in_i,
  input  logic              end_of_stream_i,
  input  logic              full_i,
  output logic              push_o,
  output wav_sd_pkg::rec_t  rec_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK_HDR, PH_FMT, PH_SKIP, PH_DATA, PH_PAD, PH_DIV, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] bc_q, bc_d, tag_q, tag_d, len_q, len_d, rate_q, rate_d, shift_q, shift_d;
  logic [15:0] fmt_q, fmt_d, ch_q, ch_d, bits_q, bits_d, chan_q, chan_d;
  logic [1:0]  pos_q, pos_d, seen_q, seen_d, mod3_q, mod3_d;
  logic [13:0] rem_q, rem_d, rem_step;
  logic [4:0]  cnt_q, cnt_d;
  logic [12:0] bps;
  logic        accept, fail_now, smp_now, bc_last, len_ok, supported;
  logic [16:0] chan_inc;
  wav_sd_pkg::rec_t rec;

  // residue of the length bytes mod 3 (256 is 1 mod 3, so bytes just add)
  function automatic logic [1:0] mod3_add(input logic [1:0] r, input logic [7:0] b);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(r) + 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    u = 3'(t[1:0]) + 3'(t[2]);
    mod3_add = (u == 3'd3) ? 2'd0 : u[1:0];
  endfunction

  assign bps        = bits_q[15:3];
  assign in_stall_o = full_i || (phase_q == PH_DIV);
  assign accept     = in_valid_i && !in_stall_o;
  assign chan_inc   = 17'(chan_q) + 17'd1;
  assign rem_step   = ({rem_q[12:0], len_q[31]} >= 14'(bps)) ?
                      {rem_q[12:0], len_q[31]} - 14'(bps) : {rem_q[12:0], len_q[31]};
  assign supported  = (fmt_q == 16'd1 && (bits_q == 16'd16 || bits_q == 16'd24 ||
                       bits_q == 16'd32)) || (fmt_q == 16'd3 && bits_q == 16'd32);

  always_comb begin
    phase_d = phase_q; bc_d = bc_q; tag_d = tag_q; len_d = len_q; rate_d = rate_q;
    shift_d = shift_q; fmt_d = fmt_q; ch_d = ch_q; bits_d = bits_q; chan_d = chan_q;
    pos_d = pos_q; seen_d = seen_q; mod3_d = mod3_q; rem_d = rem_q; cnt_d = cnt_q;
    fail_now = 1'b0; smp_now = 1'b0; bc_last = 1'b0; len_ok = 1'b0;
    rec = '0;
    rec.chan  = chan_q;
    rec.mode  = (fmt_q == 16'd3) ? wav_sd_pkg::MODE_FLOAT :
                (bits_q == 16'd16) ? wav_sd_pkg::MODE_PCM16 :
                (bits_q == 16'd24) ? wav_sd_pkg::MODE_PCM24 : wav_sd_pkg::MODE_PCM32;
    push_o = 1'b0;
    if (phase_q == PH_DIV) begin
      // serial remainder of chunk length by bytes per sample
      if (!(cnt_q == 5'd31 && full_i)) begin
        rem_d = rem_step;
        len_d = {len_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          push_o = 1'b1;
          rec.term_vld  = 1'b1;
          rec.term_kind = wav_sd_pkg::KIND_ERROR;
          rec.err = (rem_step != 14'd0) ? wav_sd_pkg::ERR_LAYOUT : wav_sd_pkg::ERR_ENCODING;
          phase_d = PH_DONE;
        end
      end
    end else if (accept && phase_q != PH_DONE) begin
      bc_d = bc_q + 32'd1;
      case (phase_q)
        PH_HEADER: begin
          if (bc_q < 32'd4) tag_d = {tag_q[23:0], byte_in_i};
          else if (bc_q >= 32'd8) len_d = {len_q[23:0], byte_in_i};
          if (bc_q == 32'd11) begin
            if (tag_d != wav_sd_pkg::TAG_RIFF || len_d != wav_sd_pkg::TAG_WAVE) begin
              fail_now = 1'b1;
              rec.err  = wav_sd_pkg::ERR_NOT_WAVE;
            end else begin
              phase_d = PH_CHUNK_HDR;
              bc_d    = '0;
            end
          end
        end
        PH_CHUNK_HDR: begin
          case (bc_q[2:0])
            3'd0, 3'd1, 3'd2, 3'd3: tag_d = {tag_q[23:0], byte_in_i};
            3'd4: begin
              len_d  = {24'd0, byte_in_i};
              mod3_d = mod3_add(2'd0, byte_in_i);
            end
            3'd5: begin len_d[15:8]  = byte_in_i; mod3_d = mod3_add(mod3_q, byte_in_i); end
            3'd6: begin len_d[23:16] = byte_in_i; mod3_d = mod3_add(mod3_q, byte_in_i); end
            default: begin
              len_d[31:24] = byte_in_i;
              mod3_d       = mod3_add(mod3_q, byte_in_i);
            end
          endcase
          if (bc_q == 32'd7) begin
            bc_d = '0;
            if (tag_q == wav_sd_pkg::TAG_FMT) begin
              if (len_d < 32'd16) begin
                fail_now = 1'b1;
                rec.err  = wav_sd_pkg::ERR_ENCODING;
              end else begin
                phase_d = PH_FMT;
              end
            end else if (tag_q == wav_sd_pkg::TAG_DATA) begin
              case (bits_q)
                16'd16:  len_ok = !len_d[0];
                16'd24:  len_ok = (mod3_d == 2'd0);
                default: len_ok = (len_d[1:0] == 2'b00);
              endcase
              if (!seen_q[0] || ch_q == 16'd0 || rate_q == 32'd0) begin
                fail_now = 1'b1;
                rec.err  = wav_sd_pkg::ERR_MISSING;
              end else if (len_d == 32'd0) begin
                phase_d = PH_CHUNK_HDR;
              end else if (bps == 13'd0) begin
                fail_now = 1'b1;
                rec.err  = wav_sd_pkg::ERR_LAYOUT;
              end else if (supported) begin
                if (!len_ok) begin
                  fail_now = 1'b1;
                  rec.err  = wav_sd_pkg::ERR_LAYOUT;
                end else begin
                  seen_d[1] = 1'b1;
                  phase_d   = PH_DATA;
                  shift_d   = '0;
                  pos_d     = '0;
                  chan_d    = '0;
                end
              end else begin
                phase_d = PH_DIV;
                rem_d   = '0;
                cnt_d   = '0;
              end
            end else if (len_d == 32'd0) begin
              phase_d = PH_CHUNK_HDR;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          case (bc_q[3:0])
            4'd0:  fmt_d = {8'd0, byte_in_i};
            4'd1:  fmt_d[15:8] = byte_in_i;
            4'd2:  ch_d = {8'd0, byte_in_i};
            4'd3:  ch_d[15:8] = byte_in_i;
            4'd4:  rate_d = {24'd0, byte_in_i};
            4'd5:  rate_d[15:8] = byte_in_i;
            4'd6:  rate_d[23:16] = byte_in_i;
            4'd7:  rate_d[31:24] = byte_in_i;
            4'd14: bits_d = {8'd0, byte_in_i};
            4'd15: bits_d[15:8] = byte_in_i;
            default: ;
          endcase
          if (bc_q == 32'd15) begin
            seen_d[0] = 1'b1;
            if (len_q == 32'd16) begin
              phase_d = len_q[0] ? PH_PAD : PH_CHUNK_HDR;
              bc_d    = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: bc_last = (bc_d == len_q);
        PH_DATA: begin
          shift_d = shift_q | ({24'd0, byte_in_i} << {pos_q, 3'b000});
          if (3'(pos_q) + 3'd1 >= bps[2:0]) begin
            smp_now = 1'b1;
            rec.raw = shift_d;
            chan_d  = (chan_inc >= 17'(ch_q)) ? 16'd0 : chan_inc[15:0];
            shift_d = '0;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 2'd1;
          end
          bc_last = (bc_d == len_q);
        end
        PH_PAD: begin
          phase_d = PH_CHUNK_HDR;
          bc_d    = '0;
        end
        default: ;
      endcase
      if (bc_last) begin
        phase_d = len_q[0] ? PH_PAD : PH_CHUNK_HDR;
        bc_d    = '0;
      end
      // end of stream judged on the state after this byte
      if (end_of_stream_i && !fail_now && phase_d != PH_DIV) begin
        if (phase_d == PH_HEADER) begin
          fail_now = 1'b1;
          rec.err  = wav_sd_pkg::ERR_NOT_WAVE;
        end else if ((phase_d == PH_CHUNK_HDR && bc_d != 32'd0) || phase_d == PH_FMT ||
                     phase_d == PH_DATA) begin
          fail_now = 1'b1;
          rec.err  = wav_sd_pkg::ERR_TRUNCATED;
        end else if (!seen_d[1]) begin
          fail_now = 1'b1;
          rec.err  = wav_sd_pkg::ERR_MISSING;
        end else begin
          rec.term_vld  = 1'b1;
          rec.term_kind = wav_sd_pkg::KIND_FINISH;
          phase_d       = PH_DONE;
        end
      end
      if (fail_now) begin
        rec.term_vld  = 1'b1;
        rec.term_kind = wav_sd_pkg::KIND_ERROR;
        phase_d       = PH_DONE;
      end
      rec.smp_vld = smp_now;
      push_o      = smp_now || rec.term_vld;
    end
    // fields as updated by this byte
    rec.rate  = rate_d;
    rec.count = ch_d;
    rec_o = rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; bc_q <= '0; tag_q <= '0; len_q <= '0; rate_q <= '0;
      shift_q <= '0; fmt_q <= '0; ch_q <= '0; bits_q <= '0; chan_q <= '0;
      pos_q <= '0; seen_q <= '0; mod3_q <= '0; rem_q <= '0; cnt_q <= '0;
    end else begin
      phase_q <= phase_d; bc_q <= bc_d; tag_q <= tag_d; len_q <= len_d; rate_q <= rate_d;
      shift_q <= shift_d; fmt_q <= fmt_d; ch_q <= ch_d; bits_q <= bits_d;
      chan_q <= chan_d; pos_q <= pos_d; seen_q <= seen_d;
      mod3_q <= mod3_d; rem_q <= rem_d; cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/wav_sd_fifo.sv
module wav_sd_fifo #(
  parameter int unsigned Depth = wav_sd_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wav_sd_pkg::rec_t wdata_i,
  input  logic             pop_i,
  output wav_sd_pkg::rec_t rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  wav_sd_pkg::rec_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(Depth));
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

### rtl/wav_sd_back.sv
module wav_sd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wav_sd_pkg::rec_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [39:0]      sample_value_o,
  output logic [15:0]      channel_index_o,
  output logic [31:0]      sample_rate_o,
  output logic [15:0]      channel_count_o,
  output logic [2:0]       error_code_o,
  output logic             last_o
);

  logic        valid_q, sent_q, load, load_smp;
  logic [1:0]  kind_q;
  logic [39:0] value_q, conv;
  logic [15:0] chan_q, count_q;
  logic [31:0] rate_q;
  logic [2:0]  err_q;
  logic        last_q;
  logic [7:0]  e, ee;
  logic [22:0] f;
  logic [23:0] m;
  logic [7:0]  sh;
  logic [38:0] mag;
  logic [31:0] r;

  // sample conversion to q3.36
  always_comb begin
    r  = head_i.raw;
    e  = r[30:23];
    f  = r[22:0];
    m  = (e != 8'd0) ? {1'b1, f} : {1'b0, f};
    ee = (e != 8'd0) ? e : 8'd1;
    sh = 8'd114 - ee;
    mag = '0;
    if (e >= 8'd129) begin
      mag = 39'(1) << 38;
    end else if (ee >= 8'd114) begin
      mag = 39'(m) << (ee - 8'd114);
    end else if (sh < 8'd26) begin
      mag = (39'(m) + (39'(1) << (sh - 8'd1))) >> sh;
    end
    if (e == 8'hFF && f != 23'd0) mag = '0;
    case (head_i.mode)
      wav_sd_pkg::MODE_PCM16: conv = {{3{r[15]}}, r[15:0], 21'd0};
      wav_sd_pkg::MODE_PCM24: conv = {{3{r[23]}}, r[23:0], 13'd0};
      wav_sd_pkg::MODE_PCM32: conv = {{3{r[31]}}, r, 5'd0};
      default: conv = r[31] ? (40'd0 - {1'b0, mag}) : {1'b0, mag};
    endcase
  end

  assign load     = (!valid_q || !out_stall_i) && !empty_i;
  assign load_smp = head_i.smp_vld && !sent_q;
  assign pop_o    = load && !(load_smp && head_i.term_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= !empty_i;
      if (load) sent_q <= load_smp && head_i.term_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rate_q  <= head_i.rate;
      count_q <= head_i.count;
      if (load_smp) begin
        kind_q  <= wav_sd_pkg::KIND_SAMPLE;
        value_q <= conv;
        chan_q  <= head_i.chan;
        err_q   <= wav_sd_pkg::ERR_NONE;
        last_q  <= !head_i.term_vld;
      end else begin
        kind_q  <= head_i.term_kind;
        value_q <= '0;
        chan_q  <= '0;
        err_q   <= head_i.err;
        last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign sample_value_o  = value_q;
  assign channel_index_o = chan_q;
  assign sample_rate_o   = rate_q;
  assign channel_count_o = count_q;
  assign error_code_o    = err_q;
  assign last_o          = last_q;

endmodule

### rtl/wav_stream_sample_decoder_core.sv
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o byte_in_i, end_of_stream_i
// out      output     out_valid_o/out_stall_i kind, sample, channel, rate, count, error, last
//
// one byte per cycle while in_stall_o is low; a data chunk header with an unsupported
//   encoding runs a serial remainder check (stall high) before its error is queued
// a byte that completes a sample and ends the stream yields two results, drained
//   by the output stage one after the other; the queue absorbs the difference
// in_stall_o rises when the transaction queue is full or the remainder check runs
// reset is asynchronous and active low; after finish or error bytes are taken and dropped
`include "wav_stream_sample_decoder_core_defines.svh"

module wav_stream_sample_decoder_core #(
  parameter int unsigned FifoDepth = wav_sd_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic signed [39:0] sample_value_o,
  output logic [15:0] channel_index_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] channel_count_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  // front parser to queue
  wav_sd_pkg::rec_t push_rec, head_rec;
  logic push, pop, q_empty, q_full;
  logic [39:0] value;

  // header/chunk walker, classifies each byte and queues the transaction
  wav_sd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .byte_in_i, .end_of_stream_i,
    .full_i (q_full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  // short queue so the parser and the output side stall independently
  wav_sd_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (head_rec),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // sample conversion and output register
  wav_sd_back u_back (
    .clk_i, .rst_ni,
    .head_i  (head_rec),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .kind_o,
    .sample_value_o (value),
    .channel_index_o, .sample_rate_o, .channel_count_o, .error_code_o, .last_o
  );

  assign sample_value_o = $signed(value);

  // queue never written while full unless a pop comes with the write
  `WSD_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push, !q_full || pop)
  // finish and error results always close their byte
  `WSD_ASSERT_IMPLIES(a_term_last, clk_i, rst_ni,
    out_valid_o && kind_o != wav_sd_pkg::KIND_SAMPLE, last_o)
  // samples carry no error code
  `WSD_ASSERT_IMPLIES(a_smp_no_err, clk_i, rst_ni,
    out_valid_o && kind_o == wav_sd_pkg::KIND_SAMPLE, error_code_o == wav_sd_pkg::ERR_NONE)
  // an error result is followed by no sample
  `WSD_ASSERT_NEXT(a_err_final, clk_i, rst_ni,
    out_valid_o && !out_stall_i && kind_o == wav_sd_pkg::KIND_ERROR, !push)

endmodule
